// File: rtl/ipid_pkg.sv
// shared types, widths and constants for the incremental pid steering block
// no dependencies; imported by every rtl module of the block
package ipid_pkg;

   // field and register widths
   localparam int PositionBitsDef = 10;
   localparam int ValueBits       = 10;
   localparam int CfgPosBits      = 10;
   localparam int LimitBits       = 15;
   localparam int DeadbandBits    = 10;
   localparam int GainBits        = 10;
   localparam int DriveBits       = 16;
   localparam int ReqDataBits     = 16;
   localparam int RspDataBits     = 16;
   localparam int CsrAddrBits     = 5;
   localparam int CsrDataBits     = 32;

   // control law constants
   localparam int ErrClamp  = 250;
   localparam int TimeScale = 1000;

   // divide by TimeScale as (x * DivRecip) >> DivShift, exact for x below 2**18
   localparam int DivRecip  = 268436;
   localparam int DivShift  = 28;
   localparam int RecipBits = 19;

   // datapath widths
   localparam int ErrBits    = 9;                       // clamped error, +-250
   localparam int ErrMagBits = 8;                       // |error| up to 250
   localparam int IProdBits  = GainBits + ErrMagBits;   // gain_i * |error|
   localparam int MulBits    = IProdBits + RecipBits;
   localparam int IQuotBits  = 8;                       // i term magnitude up to 255
   localparam int D1Bits     = 10;                      // first difference, +-500
   localparam int D2Bits     = 11;                      // second difference, +-1000
   localparam int PTermBits  = 21;
   localparam int GainDkBits = 20;                      // gain_d * 1000
   localparam int DTermBits  = 32;
   localparam int SumBits    = 33;

   // register reset values
   localparam int MinPositionRst = 0;
   localparam int MaxPositionRst = 1023;
   localparam int DriveLimitRst  = 1000;
   localparam int DeadbandRst    = 10;
   localparam int GainPRst       = 10;
   localparam int GainIRst       = 30;
   localparam int GainDRst       = 0;

   typedef enum logic [2:0] {
      REG_MIN_POSITION = 3'd0,
      REG_MAX_POSITION = 3'd1,
      REG_DRIVE_LIMIT  = 3'd2,
      REG_DEADBAND     = 3'd3,
      REG_GAIN_P       = 3'd4,
      REG_GAIN_I       = 3'd5,
      REG_GAIN_D       = 3'd6
   } reg_index_type;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_LOAD = 1'b1
   } op_type;

   typedef struct packed {
      logic [CfgPosBits-1:0]   min_position;
      logic [CfgPosBits-1:0]   max_position;
      logic [LimitBits-1:0]    drive_limit;
      logic [DeadbandBits-1:0] deadband;
      logic [GainBits-1:0]     gain_p;
      logic [GainBits-1:0]     gain_i;
      logic [GainBits-1:0]     gain_d;
      logic [GainDkBits-1:0]   gain_dk;
   } cfg_type;

   // beat handed from the error stage to the accumulator stage
   typedef struct packed {
      logic                      load;
      logic                      fault;
      logic                      armed;
      logic                      dead;
      logic signed [ErrBits-1:0] err;
      logic [IProdBits-1:0]      iprod;
   } stage_type;

endpackage

// File: rtl/incremental_pid_steering.sv
// Incremental (velocity-form) PID steering controller. Each req beat is either a target load
// (tuser high, new target in tdata) or a control tick (tuser low, measured position in tdata);
// every beat gives exactly one rsp beat with the drive held after it and a position fault flag.
// The block takes one beat per clock cycle when rsp is not stalled; each result passes the
// input register, the error stage (range check, clamp, deadband, gain_i product, registered)
// and the accumulator stage (p, d and divided i terms, sum and saturation) ahead of the
// result register. Ready walks back stage by stage, so the pipeline keeps filling while a
// result waits at rsp. After reset the target is the steering center (half the position
// range), the loop is armed and the drive is zero. Registers sit at byte address 4*index
// and must only be written while no beat is in flight.
// depends on ipid_pkg, ipid_csr, ipid_err_stage, ipid_drive_stage
module incremental_pid_steering #(
   parameter int POSITION_BITS = ipid_pkg::PositionBitsDef
) (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ipid_pkg::ReqDataBits-1:0]    req_tdata,   // [9:0] value, rest zero
   input  logic                                req_tuser,   // [0] operation
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ipid_pkg::RspDataBits-1:0]    rsp_tdata,   // [15:0] drive
   output logic                                rsp_tuser,   // [0] position_fault
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ipid_pkg::CsrAddrBits-1:0]    csr_paddr,
   input  logic [ipid_pkg::CsrDataBits-1:0]    csr_pwdata,
   output logic [ipid_pkg::CsrDataBits-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import ipid_pkg::*;

   cfg_type cfg;

   // input register
   logic                 a_valid_ff;
   logic                 a_op_ff;
   logic [ValueBits-1:0] a_value_ff;

   // error stage output valid
   logic                 b_valid_ff;
   stage_type            stage_b;

   // result register
   logic                        o_valid_ff;
   logic signed [DriveBits-1:0] o_drive_ff;
   logic                        o_fault_ff;

   logic signed [DriveBits-1:0] drive_next;
   logic                        fault_next;

   // per-stage advance: a stage may load when empty or when the stage after it moves
   logic o_en, b_en, a_en;

   assign o_en = !o_valid_ff || rsp_tready;
   assign b_en = !b_valid_ff || o_en;
   assign a_en = !a_valid_ff || b_en;

   assign req_tready = a_en;
   assign csr_pready = 1'b1;

   ipid_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   // state of the error stage moves only with a real beat
   ipid_err_stage #(
      .POSITION_BITS (POSITION_BITS)
   ) u_err (
      .clock     (clock),
      .reset     (reset),
      .take      (a_valid_ff && b_en),
      .load_en   (b_en),
      .op        (a_op_ff),
      .value     (a_value_ff),
      .cfg       (cfg),
      .stage_out (stage_b)
   );

   ipid_drive_stage u_drive (
      .clock     (clock),
      .reset     (reset),
      .take      (b_valid_ff && o_en),
      .stage_in  (stage_b),
      .cfg       (cfg),
      .drive_out (drive_next),
      .fault_out (fault_next)
   );

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (a_en) begin
            a_valid_ff <= req_tvalid;
         end
         if (b_en) begin
            b_valid_ff <= a_valid_ff;
         end
         if (o_en) begin
            o_valid_ff <= b_valid_ff;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (a_en && req_tvalid) begin
         a_op_ff    <= req_tuser;
         a_value_ff <= req_tdata[ValueBits-1:0];
      end
      if (o_en && b_valid_ff) begin
         o_drive_ff <= drive_next;
         o_fault_ff <= fault_next;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = RspDataBits'(o_drive_ff);
   assign rsp_tuser  = o_fault_ff;

endmodule

// File: rtl/ipid_csr.sv
// configuration registers behind the apb-style port
// depends on ipid_pkg
module ipid_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ipid_pkg::CsrAddrBits-1:0]   csr_paddr,
   input  logic [ipid_pkg::CsrDataBits-1:0]   csr_pwdata,
   output logic [ipid_pkg::CsrDataBits-1:0]   csr_prdata,
   output ipid_pkg::cfg_type                  cfg
);
   import ipid_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type reg_idx;
   logic          wr_en;

   assign reg_idx = reg_index_type'(csr_paddr[CsrAddrBits-1:2]);
   assign wr_en   = csr_psel && csr_penable && csr_pwrite;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_position <= CfgPosBits'(MinPositionRst);
         cfg_ff.max_position <= CfgPosBits'(MaxPositionRst);
         cfg_ff.drive_limit  <= LimitBits'(DriveLimitRst);
         cfg_ff.deadband     <= DeadbandBits'(DeadbandRst);
         cfg_ff.gain_p       <= GainBits'(GainPRst);
         cfg_ff.gain_i       <= GainBits'(GainIRst);
         cfg_ff.gain_d       <= GainBits'(GainDRst);
         cfg_ff.gain_dk      <= GainDkBits'(GainDRst * TimeScale);
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_MIN_POSITION: cfg_ff.min_position <= csr_pwdata[CfgPosBits-1:0];
            REG_MAX_POSITION: cfg_ff.max_position <= csr_pwdata[CfgPosBits-1:0];
            REG_DRIVE_LIMIT:  cfg_ff.drive_limit  <= csr_pwdata[LimitBits-1:0];
            REG_DEADBAND:     cfg_ff.deadband     <= csr_pwdata[DeadbandBits-1:0];
            REG_GAIN_P:       cfg_ff.gain_p       <= csr_pwdata[GainBits-1:0];
            REG_GAIN_I:       cfg_ff.gain_i       <= csr_pwdata[GainBits-1:0];
            REG_GAIN_D: begin
               cfg_ff.gain_d  <= csr_pwdata[GainBits-1:0];
               // derivative gain premultiplied by the time scale
               cfg_ff.gain_dk <= GainDkBits'(csr_pwdata[GainBits-1:0])
                                 * GainDkBits'(TimeScale);
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MIN_POSITION: csr_prdata = CsrDataBits'(cfg_ff.min_position);
         REG_MAX_POSITION: csr_prdata = CsrDataBits'(cfg_ff.max_position);
         REG_DRIVE_LIMIT:  csr_prdata = CsrDataBits'(cfg_ff.drive_limit);
         REG_DEADBAND:     csr_prdata = CsrDataBits'(cfg_ff.deadband);
         REG_GAIN_P:       csr_prdata = CsrDataBits'(cfg_ff.gain_p);
         REG_GAIN_I:       csr_prdata = CsrDataBits'(cfg_ff.gain_i);
         REG_GAIN_D:       csr_prdata = CsrDataBits'(cfg_ff.gain_d);
         default:          csr_prdata = '0;
      endcase
   end

endmodule

// File: rtl/ipid_err_stage.sv
// error stage: target and arm state, range check, clamp, deadband, i-term product
// depends on ipid_pkg
module ipid_err_stage #(
   parameter int POSITION_BITS = ipid_pkg::PositionBitsDef
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            take,
   input  logic                            load_en,
   input  logic                            op,
   input  logic [ipid_pkg::ValueBits-1:0]  value,
   input  ipid_pkg::cfg_type               cfg,
   output ipid_pkg::stage_type             stage_out
);
   import ipid_pkg::*;

   localparam int CmpBits  = (POSITION_BITS > CfgPosBits) ? POSITION_BITS : CfgPosBits;
   localparam int DiffBits = POSITION_BITS + 1;
   localparam logic [POSITION_BITS-1:0]   TargetCenter = POSITION_BITS'(1) << (POSITION_BITS - 1);
   localparam logic signed [DiffBits-1:0] ClampHi = DiffBits'(ErrClamp);
   localparam logic signed [DiffBits-1:0] ClampLo = DiffBits'(-ErrClamp);

   logic [POSITION_BITS-1:0]           target_ff, target_in;
   logic                               armed_ff, armed_in;
   stage_type                          stage_ff, stage_in;
   logic [ValueBits+POSITION_BITS-1:0] value_wide;
   logic [POSITION_BITS-1:0]           pos;
   logic                               is_load, out_range, dead;
   logic signed [DiffBits-1:0]         diff;
   logic signed [ErrBits-1:0]          err, err_neg;
   logic [ErrMagBits-1:0]              err_mag;

   // position keeps its low POSITION_BITS bits
   assign value_wide = {{POSITION_BITS{1'b0}}, value};
   assign pos        = value_wide[POSITION_BITS-1:0];
   assign is_load    = (op == OP_LOAD);
   assign out_range  = (CmpBits'(pos) < CmpBits'(cfg.min_position))
                    || (CmpBits'(pos) > CmpBits'(cfg.max_position));
   assign diff       = signed'({1'b0, target_ff}) - signed'({1'b0, pos});

   always_comb begin
      if (diff > ClampHi) begin
         err = ErrBits'(ErrClamp);
      end else if (diff < ClampLo) begin
         err = ErrBits'(-ErrClamp);
      end else begin
         err = ErrBits'(diff);
      end
   end

   assign err_neg = -err;
   assign err_mag = ErrMagBits'(err[ErrBits-1] ? err_neg : err);
   assign dead    = DeadbandBits'(err_mag) < cfg.deadband;

   always_comb begin
      target_in = target_ff;
      armed_in  = armed_ff;
      if (is_load) begin
         target_in = pos;
         armed_in  = 1'b1;
      end else if (!out_range && dead) begin
         armed_in  = 1'b0;
      end
      stage_in.load  = is_load;
      stage_in.fault = !is_load && out_range;
      stage_in.armed = armed_ff;
      stage_in.dead  = dead;
      stage_in.err   = err;
      stage_in.iprod = IProdBits'(cfg.gain_i) * IProdBits'(err_mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TargetCenter;
         armed_ff  <= 1'b1;
      end else if (take) begin
         target_ff <= target_in;
         armed_ff  <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

// File: rtl/ipid_drive_stage.sv
// accumulator stage: error history, p/i/d increment, drive saturation
// depends on ipid_pkg
module ipid_drive_stage (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   take,
   input  ipid_pkg::stage_type                    stage_in,
   input  ipid_pkg::cfg_type                      cfg,
   output logic signed [ipid_pkg::DriveBits-1:0]  drive_out,
   output logic                                   fault_out
);
   import ipid_pkg::*;

   logic signed [ErrBits-1:0]   err_now_ff, err_now_in;
   logic signed [ErrBits-1:0]   err_prev_ff, err_prev_in;
   logic signed [DriveBits-1:0] drive_ff, drive_in;

   logic signed [D1Bits-1:0]    d1;
   logic signed [D2Bits-1:0]    d2;
   logic signed [PTermBits-1:0] p_term;
   logic [MulBits-1:0]          iq_wide;
   logic [IQuotBits-1:0]        iq;
   logic signed [IQuotBits:0]   iq_pos, i_term;
   logic signed [DTermBits-1:0] d_term;
   logic signed [SumBits-1:0]   sum, lim_pos, lim_neg, sat;

   assign d1 = D1Bits'(stage_in.err) - D1Bits'(err_now_ff);
   assign d2 = D2Bits'(stage_in.err) - D2Bits'(err_now_ff) - D2Bits'(err_now_ff)
             + D2Bits'(err_prev_ff);

   assign p_term = PTermBits'(signed'({1'b0, cfg.gain_p})) * PTermBits'(d1);

   // i term: |gain_i * err| / 1000 by reciprocal, sign restored after
   assign iq_wide = MulBits'(stage_in.iprod) * MulBits'(DivRecip);
   assign iq      = iq_wide[DivShift +: IQuotBits];
   assign iq_pos  = signed'({1'b0, iq});
   assign i_term  = stage_in.err[ErrBits-1] ? -iq_pos : iq_pos;

   assign d_term = DTermBits'(signed'({1'b0, cfg.gain_dk})) * DTermBits'(d2);

   assign sum = SumBits'(drive_ff) + SumBits'(p_term) + SumBits'(i_term)
              + SumBits'(d_term);
   assign lim_pos = SumBits'(signed'({1'b0, cfg.drive_limit}));
   assign lim_neg = -lim_pos;

   always_comb begin
      if (sum > lim_pos) begin
         sat = lim_pos;
      end else if (sum < lim_neg) begin
         sat = lim_neg;
      end else begin
         sat = sum;
      end
   end

   always_comb begin
      drive_in    = drive_ff;
      err_now_in  = err_now_ff;
      err_prev_in = err_prev_ff;
      if (!stage_in.load) begin
         if (stage_in.fault) begin
            drive_in    = '0;
            err_now_in  = '0;
            err_prev_in = '0;
         end else begin
            err_prev_in = err_now_ff;
            err_now_in  = stage_in.err;
            if (stage_in.armed) begin
               drive_in = DriveBits'(sat);
            end
            if (stage_in.dead) begin
               drive_in    = '0;
               err_now_in  = '0;
               err_prev_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff    <= '0;
         err_now_ff  <= '0;
         err_prev_ff <= '0;
      end else if (take) begin
         drive_ff    <= drive_in;
         err_now_ff  <= err_now_in;
         err_prev_ff <= err_prev_in;
      end
   end

   assign drive_out = drive_in;
   assign fault_out = stage_in.fault;

endmodule

// File: rtl/ipid_checker.sv
// port-level checks for the incremental pid steering block, bound to the top level
// depends on ipid_pkg and incremental_pid_steering
module ipid_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [ipid_pkg::RspDataBits-1:0]    rsp_tdata,
   input logic                                rsp_tuser
);
   import ipid_pkg::*;

   // a stalled result beat holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   // a position fault always clears the drive
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("fault beat with nonzero drive");

   // drive is saturated to a 15-bit bound, never the most negative code
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata != {1'b1, {(RspDataBits-1){1'b0}}})
      else $error("drive outside symmetric range");

   // nothing leaves the pipeline right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind incremental_pid_steering ipid_checker u_ipid_checker (.*);

// File: sim/ipid_steering_checker.sv
`timescale 1ns / 100ps
// result checker for the incremental pid steering block: mirrors register writes,
// predicts the drive and fault of every request beat and compares the rsp beats in order
// depends on ipid_pkg
module ipid_steering_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [ipid_pkg::ReqDataBits-1:0]   req_tdata,
   input  logic                               req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [ipid_pkg::RspDataBits-1:0]   rsp_tdata,
   input  logic                               rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ipid_pkg::CsrAddrBits-1:0]   csr_paddr,
   input  logic [ipid_pkg::CsrDataBits-1:0]   csr_pwdata,
   input  logic                               csr_pready,
   output int                                 error_count = 0,
   output int                                 pending_count = 0
);
   import ipid_pkg::*;

   typedef struct packed {
      logic signed [DriveBits-1:0] drive;
      logic                        fault;
   } steer_result_type;

   // register mirror
   longint pos_lo, pos_hi, drive_cap, band, k_p, k_i, k_d;

   // controller state
   logic [ValueBits-1:0] aim;
   longint               e_new, e_last, e_older, drive_sum;
   bit                   loop_armed;

   steer_result_type expected_drives[$];

   task automatic report(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      error_count++;
   endtask

   function automatic steer_result_type steer_step(input op_type op,
                                                   input logic [ValueBits-1:0] value);
      steer_result_type res;
      longint           step;
      res.fault = 1'b0;
      if (op == OP_LOAD) begin
         aim = value;
         loop_armed = 1'b1;
      end else begin
         e_older = e_last;
         e_last = e_new;
         e_new = longint'(aim) - longint'(value);
         if (longint'(value) < pos_lo || longint'(value) > pos_hi) begin
            e_new = 0;
            e_last = 0;
            e_older = 0;
            drive_sum = 0;
            res.fault = 1'b1;
         end else begin
            if (e_new < -ErrClamp) e_new = -ErrClamp;
            else if (e_new > ErrClamp) e_new = ErrClamp;
            if (loop_armed) begin
               step = k_p * (e_new - e_last) + (k_i * e_new) / TimeScale
                    + k_d * TimeScale * (e_new - 2 * e_last + e_older);
               drive_sum += step;
               if (drive_sum < -drive_cap) drive_sum = -drive_cap;
               else if (drive_sum > drive_cap) drive_sum = drive_cap;
            end
            // target reached: drop the drive and the two newest errors
            if (e_new < band && e_new > -band) begin
               drive_sum = 0;
               e_new = 0;
               e_last = 0;
               loop_armed = 1'b0;
            end
         end
      end
      res.drive = drive_sum[DriveBits-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      steer_result_type want;
      if (reset) begin
         pos_lo = longint'(MinPositionRst);
         pos_hi = longint'(MaxPositionRst);
         drive_cap = longint'(DriveLimitRst);
         band = longint'(DeadbandRst);
         k_p = longint'(GainPRst);
         k_i = longint'(GainIRst);
         k_d = longint'(GainDRst);
         aim = ValueBits'(1 << (PositionBitsDef - 1));
         e_new = 0;
         e_last = 0;
         e_older = 0;
         drive_sum = 0;
         loop_armed = 1'b1;
         expected_drives.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[CsrAddrBits-1:2]))
               REG_MIN_POSITION: pos_lo = longint'(csr_pwdata[CfgPosBits-1:0]);
               REG_MAX_POSITION: pos_hi = longint'(csr_pwdata[CfgPosBits-1:0]);
               REG_DRIVE_LIMIT:  drive_cap = longint'(csr_pwdata[LimitBits-1:0]);
               REG_DEADBAND:     band = longint'(csr_pwdata[DeadbandBits-1:0]);
               REG_GAIN_P:       k_p = longint'(csr_pwdata[GainBits-1:0]);
               REG_GAIN_I:       k_i = longint'(csr_pwdata[GainBits-1:0]);
               REG_GAIN_D:       k_d = longint'(csr_pwdata[GainBits-1:0]);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_drives.size() == 0) begin
               report($sformatf("rsp beat with nothing expected, drive %0d",
                                $signed(rsp_tdata[DriveBits-1:0])));
            end else begin
               want = expected_drives.pop_front();
               if (rsp_tdata[DriveBits-1:0] !== want.drive)
                  report($sformatf("drive %0d, expected %0d",
                                   $signed(rsp_tdata[DriveBits-1:0]), want.drive));
               if (rsp_tuser !== want.fault)
                  report($sformatf("position_fault %b, expected %b", rsp_tuser, want.fault));
            end
         end
         if (req_tvalid && req_tready)
            expected_drives.push_back(steer_step(op_type'(req_tuser),
                                                 req_tdata[ValueBits-1:0]));
      end
      pending_count = expected_drives.size();
   end

endmodule

// File: sim/incremental_pid_steering_tb.sv
`timescale 1ns / 100ps
// testbench top for the incremental pid steering block: clock, reset, request and
// register stimulus, rsp back-pressure and the verdict; depends on ipid_pkg,
// incremental_pid_steering and ipid_steering_checker
module incremental_pid_steering_tb;
   import ipid_pkg::*;

   localparam int SettleCycles = 8;        // pipeline is three deep, leave some margin
   localparam int CycleLimit   = 400000;   // watchdog limit, far above the slowest legal run
   localparam int LongHold     = 300;      // rsp stall long enough to back up the pipeline
   localparam logic [2:0] RegUnused = 3'd7; // address past the register list

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ReqDataBits-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspDataBits-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CsrAddrBits-1:0] csr_paddr = '0;
   logic [CsrDataBits-1:0] csr_pwdata = '0;
   logic [CsrDataBits-1:0] csr_prdata;
   logic                   csr_pready;

   int  error_count;
   int  pending_count;
   int  cycles = 0;
   int  holds_asked = 0;    // bumped by the sender, served by the rsp process
   int  holds_done = 0;
   bit  send_calm = 1'b0;   // sender runs without gaps while set

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   incremental_pid_steering uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ipid_steering_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // idle length: none in calm mode, else mostly none, often a short gap, now and then a long gap
   function automatic int idle_len(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // mostly a typical value, sometimes one of the extremes of the register
   function automatic int pick_reg(input int typ_lo, input int typ_hi, input int top);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return top;
      return $urandom_range(typ_lo, typ_hi);
   endfunction

   // one request beat; valid stays high into the next beat unless a gap is drawn
   task automatic send_beat(input op_type op, input int value);
      int gap;
      gap = idle_len(send_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= ReqDataBits'(value);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // setup and access phase; junk in the upper data bits must be masked off
   task automatic csr_write(input logic [2:0] index, input int value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= (32'($urandom_range(0, 65535)) << 16) | 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // stop offering beats and wait for every expected rsp beat, then let the pipe empty
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic setup(input int lo, input int hi, input int cap, input int dead,
                        input int kp, input int ki, input int kd);
      settle();
      csr_write(REG_MIN_POSITION, lo);
      csr_write(REG_MAX_POSITION, hi);
      csr_write(REG_DRIVE_LIMIT, cap);
      csr_write(REG_DEADBAND, dead);
      csr_write(REG_GAIN_P, kp);
      csr_write(REG_GAIN_I, ki);
      csr_write(REG_GAIN_D, kd);
   endtask

   task automatic random_setup();
      int lo, hi;
      lo = pick_reg(0, 300, 1023);
      hi = pick_reg(700, 1023, 1023);
      // once in a while swap the limits so every tick faults
      if ($urandom_range(0, 11) == 0) begin
         lo = $urandom_range(600, 1023);
         hi = $urandom_range(0, 400);
      end
      setup(lo, hi, pick_reg(100, 5000, 32767), pick_reg(0, 20, 1023),
            pick_reg(0, 60, 1023), pick_reg(0, 1023, 1023), pick_reg(0, 3, 1023));
      if ($urandom_range(0, 3) == 0) csr_write(RegUnused, $urandom_range(0, 32767));
   endtask

   // a new target, then a servo that closes in on it with a bit of noise and the odd
   // sensor glitch; this is what keeps the loop armed and exercises the i and d terms
   task automatic run_track(input int ticks);
      int aim, pos;
      aim = $urandom_range(0, 1023);
      pos = $urandom_range(0, 1023);
      send_beat(OP_LOAD, aim);
      repeat (ticks) begin
         if ($urandom_range(0, 19) == 0)
            pos = $urandom_range(0, 1023);
         else
            pos = pos + ((aim - pos) * int'($urandom_range(1, 6))) / 8
                + int'($urandom_range(0, 6)) - 3;
         if (pos < 0) pos = 0;
         if (pos > 1023) pos = 1023;
         send_beat(OP_TICK, pos);
      end
   endtask

   // rsp side: random stalls in stretches, calm stretches with none, and the long hold
   initial begin : rsp_drain
      int  stall;
      int  span;
      bit  calm;
      span = 0;
      calm = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done != holds_asked) begin
            rsp_tready <= 1'b0;
            repeat (LongHold) @(negedge clock);
            holds_done++;
         end
         if (span == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            span = $urandom_range(30, 150);
         end
         span--;
         stall = idle_len(calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin : stimulus
      int phase, sent, n;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: center tick disarms, disarmed tick leaves the drive alone,
      // full-scale errors clamp, and a deadband hit zeroes the drive
      send_beat(OP_TICK, 512);
      send_beat(OP_TICK, 700);
      send_beat(OP_LOAD, 0);
      send_beat(OP_TICK, 1023);
      send_beat(OP_TICK, 1023);
      send_beat(OP_LOAD, 1023);
      send_beat(OP_TICK, 0);
      send_beat(OP_TICK, 1020);

      // all gains at full scale, widest drive limit, no deadband, narrow position window
      setup(100, 900, 32767, 0, 1023, 1023, 1023);
      csr_write(RegUnused, 32767);
      send_beat(OP_TICK, 99);
      send_beat(OP_TICK, 901);
      send_beat(OP_LOAD, 1023);
      send_beat(OP_TICK, 100);
      send_beat(OP_TICK, 900);
      send_beat(OP_TICK, 100);
      send_beat(OP_LOAD, 0);
      send_beat(OP_TICK, 900);

      // lowered drive limit: load reports the old drive, the next tick re-saturates
      settle();
      csr_write(REG_DRIVE_LIMIT, 100);
      send_beat(OP_LOAD, 512);
      send_beat(OP_TICK, 500);

      // swapped limits fault on every tick
      setup(800, 200, 0, 1023, 0, 0, 0);
      send_beat(OP_TICK, 500);
      send_beat(OP_TICK, 0);
      send_beat(OP_TICK, 1023);

      // zero drive limit with a deadband that always catches
      setup(0, 1023, 0, 1023, 1023, 1023, 1023);
      send_beat(OP_LOAD, 300);
      send_beat(OP_TICK, 300);
      send_beat(OP_TICK, 0);

      // back-pressure: rsp holds off while beats keep coming, so the block fills up
      setup(0, 1023, 2000, 5, 20, 500, 1);
      send_calm = 1'b1;
      holds_asked++;
      run_track(39);
      send_calm = 1'b0;

      // random phases, each with its own register setting
      for (phase = 0; phase < 8; phase++) begin
         random_setup();
         send_calm = (phase % 3 == 1);
         sent = 0;
         while (sent < 110) begin
            if ($urandom_range(0, 4) == 0) begin
               // stray beat: any operation, any value
               send_beat(op_type'($urandom_range(0, 1)), $urandom_range(0, 1023));
               sent++;
            end else begin
               n = $urandom_range(4, 20);
               run_track(n);
               sent += n + 1;
            end
         end
      end

      settle();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
